// ===== hdl/kmd_pkg.sv =====
// Package for the key matrix debouncer: item, result and config types,
// opcodes, register indexes and reset values. No dependencies.
`timescale 1ns / 1ps

package kmd_pkg;

    localparam int KEY_W        = 32;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_COUNT_DEF = 4;

    localparam logic [7:0]  STABLE_TICKS_RESET = 8'd5;
    localparam logic [15:0] IDLE_LIMIT_RESET   = 16'd500;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_RESEND = 2'd1,
        OP_WAKE   = 2'd2
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 1'b1;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key_sample;
    } t_item;

    typedef struct packed {
        logic [7:0]  stable_ticks_needed;
        logic [15:0] idle_ticks_limit;
    } t_cfg;

    typedef struct packed {
        logic             send_report;
        logic [KEY_W-1:0] report_keys;
        logic             sleep_enter;
        logic             asleep_status;
    } t_result;

endpackage

// ===== hdl/kmd_cfg_regs.sv =====
// Configuration register file of the key matrix debouncer.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output kmd_pkg::t_cfg                  o_cfg
);
    import kmd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_ticks_needed <= STABLE_TICKS_RESET;
            r_cfg.idle_ticks_limit    <= IDLE_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STABLE_TICKS: r_cfg.stable_ticks_needed <= i_cfg_data[7:0];
                CFG_IDLE_LIMIT:   r_cfg.idle_ticks_limit    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/kmd_in_stage.sv =====
// Input register of the key matrix debouncer; holds one item for the core.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kmd_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output kmd_pkg::t_item o_item
);
    import kmd_pkg::*;

    logic  r_vld;
    t_item r_item;

    // free when empty or when the held item moves on this cycle
    assign o_ready = !r_vld || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

// ===== hdl/kmd_core.sv =====
// Debounce and idle-sleep state with its single-pass next-state logic.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_core #(
    parameter int ROW_COUNT = kmd_pkg::ROW_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  kmd_pkg::t_item   i_item,
    input  kmd_pkg::t_cfg    i_cfg,
    output kmd_pkg::t_result o_result
);
    import kmd_pkg::*;

    localparam logic [KEY_W-1:0] ROW_MASK = (ROW_COUNT >= 4) ? {KEY_W{1'b1}} :
        KEY_W'((64'd1 << (8 * ROW_COUNT)) - 64'd1);

    logic [KEY_W-1:0] r_stable_keys,    n_stable_keys;
    logic [KEY_W-1:0] r_candidate_keys, n_candidate_keys;
    logic             r_settling,       n_settling;
    logic [7:0]       r_settle_count,   n_settle_count;
    logic [15:0]      r_idle_count,     n_idle_count;
    logic             r_sleeping,       n_sleeping;

    logic [KEY_W-1:0] sample;
    logic [7:0]       need;
    logic             send;
    logic             enter;

    assign sample = i_item.key_sample & ROW_MASK;
    assign need   = (i_cfg.stable_ticks_needed == 8'd0) ? 8'd1 : i_cfg.stable_ticks_needed;

    always_comb begin
        n_stable_keys    = r_stable_keys;
        n_candidate_keys = r_candidate_keys;
        n_settling       = r_settling;
        n_settle_count   = r_settle_count;
        n_idle_count     = r_idle_count;
        n_sleeping       = r_sleeping;
        send             = 1'b0;
        enter            = 1'b0;

        unique case (i_item.opcode)
            OP_SCAN: begin
                if (!r_sleeping) begin
                    if (r_settling) begin
                        if (sample == r_candidate_keys) begin
                            if (r_settle_count != 8'hFF) begin
                                n_settle_count = r_settle_count + 8'd1;
                                if (n_settle_count == need) begin
                                    n_stable_keys = r_candidate_keys;
                                    send          = 1'b1;
                                end
                            end
                        end else begin
                            n_settling = 1'b0;
                        end
                    end else if (sample != r_stable_keys) begin
                        n_candidate_keys = sample;
                        n_settling       = 1'b1;
                        n_settle_count   = 8'd0;
                    end

                    if (sample == '0) begin
                        if (r_idle_count != 16'hFFFF) begin
                            n_idle_count = r_idle_count + 16'd1;
                        end
                        if (n_idle_count > i_cfg.idle_ticks_limit) begin
                            n_sleeping = 1'b1;
                            enter      = 1'b1;
                        end
                    end else begin
                        n_idle_count = 16'd0;
                    end
                end
            end
            OP_RESEND: begin
                send = !r_sleeping;
            end
            OP_WAKE: begin
                n_sleeping   = 1'b0;
                n_idle_count = 16'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_keys    <= '0;
            r_candidate_keys <= '0;
            r_settling       <= 1'b0;
            r_settle_count   <= 8'd0;
            r_idle_count     <= 16'd0;
            r_sleeping       <= 1'b0;
        end else if (i_advance) begin
            r_stable_keys    <= n_stable_keys;
            r_candidate_keys <= n_candidate_keys;
            r_settling       <= n_settling;
            r_settle_count   <= n_settle_count;
            r_idle_count     <= n_idle_count;
            r_sleeping       <= n_sleeping;
        end
    end

    assign o_result.send_report   = send;
    assign o_result.report_keys   = n_stable_keys;
    assign o_result.sleep_enter   = enter;
    assign o_result.asleep_status = n_sleeping;

`ifndef SYNTHESIS
    a_enter_sleeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && enter |-> n_sleeping)
        else $error("sleep entered without asleep status");

    a_sleep_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleeping && !(i_advance && i_item.opcode == OP_WAKE)
        |=> r_sleeping && $stable(r_stable_keys))
        else $error("sleep left or key state changed without wake");

    a_keys_need_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_advance && send && i_item.opcode == OP_SCAN) |=> $stable(r_stable_keys))
        else $error("reported keys changed without a report");
`endif

endmodule

// ===== hdl/kmd_out_stage.sv =====
// Result register of the key matrix debouncer; holds a result until taken.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  kmd_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output kmd_pkg::t_result o_result
);
    import kmd_pkg::*;

    logic    r_vld;
    t_result r_result;

    assign o_can_load = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_can_load) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_result;

endmodule

// ===== hdl/key_matrix_debounce_idle.sv =====
// Top level of the key matrix snapshot debouncer with idle sleep.
// Depends on kmd_pkg, kmd_cfg_regs, kmd_in_stage, kmd_core, kmd_out_stage.
`timescale 1ns / 1ps

// Key matrix debouncer. Each input transaction is one event: a scan tick with
// a full matrix sample (one byte per row, row 0 low), a maintenance resend, or
// a wake. Exactly one result transaction comes back per event, in order,
// carrying the debounced key state after the event, a report strobe, a
// sleep-entry strobe and the sleep status. Throughput is one transaction per
// clock while the result side is ready. The accepting edge loads the input
// register; once the result register has room, the single-pass state update
// is loaded into the result register. The settle and idle counters are
// updated in that one pass, which is what lets the next event enter the input
// register while the previous one moves on. Configuration writes (register 0:
// stable tick count, register 1: idle tick limit) are always accepted and must
// only be issued while no event is in flight.
module key_matrix_debounce_idle #(
    parameter int ROW_COUNT = kmd_pkg::ROW_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // event channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [kmd_pkg::KEY_W-1:0]      i_key_sample,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_send_report,
    output logic [kmd_pkg::KEY_W-1:0]      o_report_keys,
    output logic                           o_sleep_enter,
    output logic                           o_asleep_status,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kmd_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_item   held_item;
    t_result core_result;
    t_result out_result;
    logic    held_vld;
    logic    can_load;
    logic    advance;

    assign in_item.opcode     = i_opcode;
    assign in_item.key_sample = i_key_sample;

    // held event moves through the core when the result register has room
    assign advance = held_vld && can_load;

    assign o_cfg_ready = 1'b1;

    kmd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    kmd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_vld),
        .o_item    (held_item)
    );

    kmd_core #(
        .ROW_COUNT (ROW_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    kmd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_send_report   = out_result.send_report;
    assign o_report_keys   = out_result.report_keys;
    assign o_sleep_enter   = out_result.sleep_enter;
    assign o_asleep_status = out_result.asleep_status;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for key_matrix_debounce_idle: directed and random
// events, checked against an in-bench model of the debouncer. Needs kmd_pkg.
`timescale 1ns / 1ps

module testbench;
    import kmd_pkg::*;

    localparam int ROWS     = ROW_COUNT_DEF;
    // Only the low ROWS bytes of a sample take part in any compare.
    localparam logic [KEY_W-1:0] ROW_MASK = (ROWS >= 4) ? 32'hFFFF_FFFF :
                                            32'((64'd1 << (8 * ROWS)) - 64'd1);
    localparam logic [1:0] OP_RESERVED = 2'd3;   // not decoded, must be ignored
    localparam int HOLD_LEN   = 300;             // long result-side hold-off
    localparam int DRAIN_WAIT = 8;               // extra cycles after the last result is due

    typedef enum int {
        FLOW_FREE,          // no idling on either side
        FLOW_SEND_GAPS,     // sender idles with a chance of 72 in 100
        FLOW_RECV_STALLS,   // receiver stalls with a chance of 72 in 100
        FLOW_BOTH           // both idle with a chance of 9 in 100
    } t_flow;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (all driven to known values from time 0)
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_opcode = '0;
    logic [KEY_W-1:0]      i_key_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_send_report;
    logic [KEY_W-1:0]      o_report_keys;
    logic                  o_sleep_enter;
    logic                  o_asleep_status;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    key_matrix_debounce_idle #(
        .ROW_COUNT(ROWS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_key_sample   (i_key_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_send_report  (o_send_report),
        .o_report_keys  (o_report_keys),
        .o_sleep_enter  (o_sleep_enter),
        .o_asleep_status(o_asleep_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_item      event_q[$];        // events waiting to be offered
    t_reg_write reg_write_q[$];    // register writes waiting to be offered
    t_result    expected_q[$];     // predicted results, oldest first
    int         events_queued = 0;
    int         mismatch_count = 0;
    t_flow      flow = FLOW_FREE;  // changed by the sequencer on falling edges only
    bit         pressure_on = 1'b0;
    int         hold_count = 0;

    // Model copy of the register file, updated when a write transaction lands.
    logic [7:0]  cfg_stable_ticks = STABLE_TICKS_RESET;
    logic [15:0] cfg_idle_limit   = IDLE_LIMIT_RESET;

    // Model copy of the debouncer state.
    logic [KEY_W-1:0] keys_stable    = '0;
    logic [KEY_W-1:0] keys_candidate = '0;
    logic             settling       = 1'b0;
    logic [7:0]       settle_cnt     = '0;
    logic [15:0]      idle_cnt       = '0;
    logic             asleep         = 1'b0;

    // Applies one accepted event to the model state and returns the result
    // the block must produce for it.
    function automatic t_result advance_debouncer(input t_item ev);
        logic [KEY_W-1:0] smp;
        logic [7:0]       need;
        t_result          r;
        smp  = ev.key_sample & ROW_MASK;
        need = (cfg_stable_ticks == 8'd0) ? 8'd1 : cfg_stable_ticks;
        r    = '0;
        case (ev.opcode)
            OP_SCAN: begin
                if (!asleep) begin
                    if (settling) begin
                        if (smp == keys_candidate) begin
                            // Count saturates at 255: at most one report per settle.
                            if (settle_cnt != 8'hFF) begin
                                settle_cnt = settle_cnt + 8'd1;
                                if (settle_cnt == need) begin
                                    keys_stable   = keys_candidate;
                                    r.send_report = 1'b1;
                                end
                            end
                        end else begin
                            settling = 1'b0;
                        end
                    end else if (smp != keys_stable) begin
                        keys_candidate = smp;
                        settling       = 1'b1;
                        settle_cnt     = '0;
                    end
                    if (smp == '0) begin
                        if (idle_cnt != 16'hFFFF)
                            idle_cnt = idle_cnt + 16'd1;
                        if (idle_cnt > cfg_idle_limit) begin
                            asleep        = 1'b1;
                            r.sleep_enter = 1'b1;
                        end
                    end else begin
                        idle_cnt = '0;
                    end
                end
            end
            OP_RESEND: begin
                if (!asleep)
                    r.send_report = 1'b1;
            end
            OP_WAKE: begin
                asleep   = 1'b0;
                idle_cnt = '0;
            end
            default: ;   // reserved opcode: no state change
        endcase
        r.report_keys   = keys_stable;
        r.asleep_status = asleep;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    function automatic bit sender_idles();
        case (flow)
            FLOW_SEND_GAPS: return $urandom_range(0, 99) < 72;
            FLOW_BOTH:      return $urandom_range(0, 99) < 9;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (flow)
            FLOW_RECV_STALLS: return $urandom_range(0, 99) < 72;
            FLOW_BOTH:        return $urandom_range(0, 99) < 9;
            default:          return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Event driver: predicts on each accepted transaction, then offers the
    // next queued event. Valid is held with a stable payload until accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : event_drive
        t_item cur;
        t_item nxt;
        bit    took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                cur.opcode     = i_opcode;
                cur.key_sample = i_key_sample;
                expected_q.push_back(advance_debouncer(cur));
            end
            if (!i_in_valid || took) begin
                if (event_q.size() != 0 && !sender_idles()) begin
                    nxt = event_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_opcode     <= nxt.opcode;
                    i_key_sample <= nxt.key_sample;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver; the model registers follow each accepted write.
    always @(posedge i_clk) begin : reg_drive
        t_reg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_STABLE_TICKS)
                    cfg_stable_ticks = i_cfg_data[7:0];
                else
                    cfg_idle_limit = i_cfg_data;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_write_q.size() != 0) begin
                    w = reg_write_q.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= w.index;
                    i_cfg_data  <= w.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter for the back-pressure phase: once armed it keeps the
    // result side stalled until the count reaches HOLD_LEN so the pipeline fills up.
    always @(posedge i_clk) begin
        if (pressure_on && hold_count < HOLD_LEN)
            hold_count <= hold_count + 1;
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted result is checked against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        bit      holding;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result (report_keys)", o_report_keys, '0);
            end else begin
                want = expected_q.pop_front();
                if (o_send_report !== want.send_report)
                    report_mismatch("send_report", o_send_report, want.send_report);
                if (o_report_keys !== want.report_keys)
                    report_mismatch("report_keys", o_report_keys, want.report_keys);
                if (o_sleep_enter !== want.sleep_enter)
                    report_mismatch("sleep_enter", o_sleep_enter, want.sleep_enter);
                if (o_asleep_status !== want.asleep_status)
                    report_mismatch("asleep_status", o_asleep_status, want.asleep_status);
            end
        end
        holding = pressure_on && hold_count < HOLD_LEN;
        i_out_ready <= i_rst_n && !holding && !receiver_stalls();
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (called from the sequencer on falling edges)
    // ------------------------------------------------------------------
    task automatic push_event(input logic [1:0] op, input logic [KEY_W-1:0] keys);
        t_item it;
        it.opcode     = op;
        it.key_sample = keys;
        event_q.push_back(it);
        events_queued++;
    endtask

    // Waits until nothing is queued, offered or outstanding.
    task automatic wait_quiet();
        while (event_q.size() != 0 || i_in_valid || expected_q.size() != 0 ||
               reg_write_q.size() != 0 || i_cfg_valid)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        t_reg_write w;
        wait_quiet();
        w.index = idx;
        w.data  = data;
        reg_write_q.push_back(w);
        while (reg_write_q.size() != 0 || i_cfg_valid)
            @(negedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_keys();
        case ($urandom_range(0, 9))
            0, 1, 2: return '0;
            3, 4, 5: return 32'h1 << $urandom_range(0, 31);
            6, 7:    return (32'h1 << $urandom_range(0, 31)) |
                            (32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Random traffic shaped like real keyboard activity: bouncy presses that
    // settle for about the required count, release runs near the idle limit (short
    // ones when the limit is large), resends and wakes, with a share of fully random events as noise.
    task automatic random_events(input int count);
        int               start;
        int               run;
        int               need;
        logic [KEY_W-1:0] target;
        start = events_queued;
        need  = (cfg_stable_ticks == 8'd0) ? 1 : cfg_stable_ticks;
        while (events_queued - start < count) begin
            case ($urandom_range(0, 99)) inside
                [0:54]: begin
                    target = pick_keys();
                    repeat ($urandom_range(0, 3))
                        push_event(OP_SCAN, target ^ (32'h1 << $urandom_range(0, 31)));
                    run = need + $urandom_range(0, 3);
                    if ($urandom_range(0, 4) == 0)
                        run = $urandom_range(1, need);   // released before settling
                    if (run > 300)
                        run = 300;
                    repeat (run + 1)
                        push_event(OP_SCAN, target);
                end
                [55:69]: begin
                    run = (cfg_idle_limit < 400) ? cfg_idle_limit + $urandom_range(0, 3)
                                                 : $urandom_range(1, 40);
                    repeat (run)
                        push_event(OP_SCAN, '0);
                    // scans that a sleeping block has to ignore
                    repeat ($urandom_range(0, 2))
                        push_event(OP_SCAN, pick_keys());
                    if ($urandom_range(0, 9) < 8)
                        push_event(OP_WAKE, $urandom);
                end
                [70:79]: push_event(OP_RESEND, $urandom);
                [80:87]: push_event(OP_WAKE, $urandom);
                [88:92]: push_event(OP_RESERVED, $urandom);
                default: push_event(2'($urandom_range(0, 3)), $urandom);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        int spins;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset registers (5 ticks, limit 500): press, settle, report,
        // counter running past the target, resend, bounce, reserved opcode,
        // wake while awake, upper rows.
        push_event(OP_SCAN, '0);
        repeat (7) push_event(OP_SCAN, 32'hFFFF_FFFF);
        push_event(OP_RESEND, 32'h0);
        push_event(OP_SCAN, 32'h0000_00A5);
        push_event(OP_SCAN, 32'h0000_00A5);
        push_event(OP_RESERVED, 32'hFFFF_FFFF);
        push_event(OP_SCAN, 32'h0000_00A4);
        push_event(OP_WAKE, 32'hFFFF_FFFF);
        push_event(OP_SCAN, 32'h8000_0001);
        push_event(OP_SCAN, 32'h8000_0002);

        // Zero tick count acts as one; zero idle limit sleeps on the first
        // empty scan. Scans and resends while asleep are ignored.
        write_reg(CFG_STABLE_TICKS, 16'd0);
        write_reg(CFG_IDLE_LIMIT, 16'd0);
        push_event(OP_SCAN, 32'h0000_00FF);
        push_event(OP_SCAN, 32'h0000_00FF);
        push_event(OP_SCAN, '0);
        push_event(OP_SCAN, 32'h0000_FFFF);
        push_event(OP_RESEND, '0);
        push_event(OP_RESERVED, '0);
        push_event(OP_WAKE, '0);
        push_event(OP_SCAN, '0);
        push_event(OP_WAKE, '0);
        push_event(OP_SCAN, '0);
        push_event(OP_WAKE, '0);
        push_event(OP_RESEND, '0);

        // Saturation: 255 ticks reports once and never again for the same
        // settle. The largest idle limit keeps the block awake through a long
        // empty run; lowering the limit to the count reached trips sleep on
        // the next empty scan.
        write_reg(CFG_STABLE_TICKS, 16'd255);
        write_reg(CFG_IDLE_LIMIT, 16'd65535);
        repeat (262) push_event(OP_SCAN, 32'h5A5A_5A5A);
        repeat (300) push_event(OP_SCAN, '0);
        write_reg(CFG_IDLE_LIMIT, 16'd300);
        push_event(OP_SCAN, '0);
        push_event(OP_WAKE, '0);

        // Random phases, one per idling style.
        write_reg(CFG_STABLE_TICKS, 16'd1);
        write_reg(CFG_IDLE_LIMIT, 16'd1);
        random_events(200);

        write_reg(CFG_STABLE_TICKS, 16'd3);
        write_reg(CFG_IDLE_LIMIT, 16'd20);
        flow = FLOW_SEND_GAPS;
        random_events(250);

        // Upper data bits are dropped for the 8-bit tick register.
        write_reg(CFG_STABLE_TICKS, 16'hFF02);
        write_reg(CFG_IDLE_LIMIT, 16'd8);
        flow = FLOW_RECV_STALLS;
        random_events(250);

        write_reg(CFG_STABLE_TICKS, 16'd7);
        write_reg(CFG_IDLE_LIMIT, 16'd40);
        flow = FLOW_BOTH;
        random_events(250);

        // Back-pressure: results held off for a long stretch while events keep
        // coming, so the input side has to stall.
        write_reg(CFG_STABLE_TICKS, 16'd4);
        write_reg(CFG_IDLE_LIMIT, 16'd12);
        flow        = FLOW_FREE;
        pressure_on = 1'b1;
        random_events(250);
        wait_quiet();
        pressure_on = 1'b0;

        // A few short phases with random settings and random idling.
        repeat (4) begin
            write_reg(CFG_STABLE_TICKS, 16'($urandom_range(1, 12)));
            write_reg(CFG_IDLE_LIMIT, 16'($urandom_range(1, 60)));
            flow = t_flow'($urandom_range(0, 3));
            random_events(75);
        end

        // Drain: everything offered, then wait for the outstanding results.
        while (event_q.size() != 0 || i_in_valid)
            @(negedge i_clk);
        spins = 0;
        while (expected_q.size() != 0 && spins < 5000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch("results never returned (count)", expected_q.size(), '0);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit: a run that never finishes is stopped and counted as failed.
    initial begin : watchdog
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kmd_pkg.sv
hdl/kmd_cfg_regs.sv
hdl/kmd_in_stage.sv
hdl/kmd_core.sv
hdl/kmd_out_stage.sv
hdl/key_matrix_debounce_idle.sv
sim/testbench.sv
